[hdl/wrd_pkg.sv]
// Shared types and constants of the word RLE decoder.
package wrd_pkg;

    localparam logic [7:0]  CTRL_CNT_REP      = 8'h00;
    localparam logic [7:0]  CTRL_CNT_LIT      = 8'h01;
    localparam logic [8:0]  LIT_BASE          = 9'h100;
    localparam logic [15:0] TOTAL_WORDS_RESET = 16'd16000;
    localparam logic [0:0]  REG_TOTAL_WORDS   = 1'b0;

    typedef enum logic [2:0] {
        KIND_WORD,
        KIND_LIT_SHORT,
        KIND_CNT_REP,
        KIND_CNT_LIT,
        KIND_REP_SHORT
    } t_item_kind;

    typedef struct packed {
        t_item_kind  kind;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic [15:0] run_word;
        logic [15:0] run_count;
        logic        image_done;
        logic        stream_error;
    } t_result;

    typedef struct packed {
        logic [15:0] words_left;
        logic        done;
    } t_back_status;

endpackage

[hdl/wrd_front.sv]
// Front end: accepts words, classifies them and queues them for the back end.
module wrd_front
    import wrd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_func,
    input  logic [15:0] i_item_value,
    output logic        o_full,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push_fire, pop_fire;
    t_item          new_item;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_item_valid = (r_count != '0);
    assign push_fire    = i_push && !o_full;
    assign pop_fire     = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        new_item.value = i_item_value;
        if (i_func) begin
            new_item.kind = KIND_WORD;
        end else begin
            case (i_item_value[7:0]) inside
                [8'h80:8'hFF]: new_item.kind = KIND_LIT_SHORT;
                CTRL_CNT_REP:  new_item.kind = KIND_CNT_REP;
                CTRL_CNT_LIT:  new_item.kind = KIND_CNT_LIT;
                default:       new_item.kind = KIND_REP_SHORT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_fire, pop_fire})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/wrd_back.sv]
// Back end: run-length decode state machine, one queued word per cycle while the result queue has room.
module wrd_back
    import wrd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_load,
    input  logic [15:0]  i_cfg_total,
    input  logic         i_item_valid,
    input  t_item        i_item,
    output logic         o_item_pop,
    input  logic         i_out_space,
    output logic         o_res_valid,
    output t_result      o_res,
    output t_back_status o_status
);

    typedef enum logic [2:0] {
        PH_CTRL,
        PH_CNT_HI,
        PH_CNT_LO,
        PH_REPEAT,
        PH_LITERAL,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_pend_lit, n_pend_lit;
    logic [15:0] r_run_left, n_run_left;
    logic [15:0] r_words_left, n_words_left;

    logic        fire, is_word;
    logic [7:0]  ctrl;
    logic [15:0] val;

    assign fire       = i_item_valid && i_out_space;
    assign o_item_pop = fire;
    assign is_word    = (i_item.kind == KIND_WORD);
    assign val        = i_item.value;
    assign ctrl       = i_item.value[7:0];

    assign o_status.words_left = r_words_left;
    assign o_status.done       = (r_phase == PH_DONE);

    always_comb begin
        logic        clip;
        logic [15:0] cnt;
        logic [15:0] wl_new;
        logic [15:0] rl_new;
        clip         = 1'b0;
        cnt          = '0;
        wl_new       = '0;
        rl_new       = '0;
        n_phase      = r_phase;
        n_pend_lit   = r_pend_lit;
        n_run_left   = r_run_left;
        n_words_left = r_words_left;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (fire) begin
            case (r_phase)
                PH_DONE: begin
                    o_res_valid        = 1'b1;
                    o_res.run_word     = is_word ? val : 16'd0;
                    o_res.image_done   = 1'b1;
                    o_res.stream_error = 1'b1;
                end
                PH_REPEAT, PH_LITERAL: begin
                    o_res_valid = 1'b1;
                    if (!is_word) begin
                        o_res.stream_error = 1'b1;
                    end else if (r_phase == PH_REPEAT) begin
                        clip         = (r_run_left > r_words_left);
                        cnt          = clip ? r_words_left : r_run_left;
                        wl_new       = r_words_left - cnt;
                        n_words_left = wl_new;
                        n_run_left   = '0;
                        n_phase      = (wl_new == '0) ? PH_DONE : PH_CTRL;
                        o_res.run_word     = val;
                        o_res.run_count    = cnt;
                        o_res.image_done   = (wl_new == '0);
                        o_res.stream_error = clip;
                    end else begin
                        wl_new       = r_words_left - 16'd1;
                        rl_new       = r_run_left - 16'd1;
                        n_words_left = wl_new;
                        n_run_left   = rl_new;
                        if (wl_new == '0) begin
                            n_phase = PH_DONE;
                        end else if (rl_new == '0) begin
                            n_phase = PH_CTRL;
                        end
                        o_res.run_word     = val;
                        o_res.run_count    = 16'd1;
                        o_res.image_done   = (wl_new == '0);
                        o_res.stream_error = (wl_new == '0) && (rl_new != '0);
                    end
                end
                default: begin
                    if (is_word) begin
                        o_res_valid        = 1'b1;
                        o_res.run_word     = val;
                        o_res.stream_error = 1'b1;
                    end else if (r_phase == PH_CNT_HI) begin
                        n_run_left = {ctrl, 8'd0};
                        n_phase    = PH_CNT_LO;
                    end else if (r_phase == PH_CNT_LO) begin
                        rl_new     = r_run_left | {8'd0, ctrl};
                        n_run_left = rl_new;
                        if (r_pend_lit) begin
                            n_phase = (rl_new == '0) ? PH_CTRL : PH_LITERAL;
                        end else begin
                            n_phase = PH_REPEAT;
                        end
                    end else begin
                        case (i_item.kind)
                            KIND_LIT_SHORT: begin
                                n_run_left = {7'd0, LIT_BASE - {1'b0, ctrl}};
                                n_pend_lit = 1'b1;
                                n_phase    = PH_LITERAL;
                            end
                            KIND_CNT_REP: begin
                                n_pend_lit = 1'b0;
                                n_phase    = PH_CNT_HI;
                            end
                            KIND_CNT_LIT: begin
                                n_pend_lit = 1'b1;
                                n_phase    = PH_CNT_HI;
                            end
                            default: begin
                                n_run_left = {8'd0, ctrl};
                                n_pend_lit = 1'b0;
                                n_phase    = PH_REPEAT;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= (TOTAL_WORDS_RESET == '0) ? PH_DONE : PH_CTRL;
            r_pend_lit   <= 1'b0;
            r_run_left   <= '0;
            r_words_left <= TOTAL_WORDS_RESET;
        end else if (i_cfg_load) begin
            r_phase      <= (i_cfg_total == '0) ? PH_DONE : PH_CTRL;
            r_pend_lit   <= 1'b0;
            r_run_left   <= '0;
            r_words_left <= i_cfg_total;
        end else begin
            r_phase      <= n_phase;
            r_pend_lit   <= n_pend_lit;
            r_run_left   <= n_run_left;
            r_words_left <= n_words_left;
        end
    end

endmodule

[hdl/wrd_outq.sv]
// Result queue between the back end and the result ports.
module wrd_outq
    import wrd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_empty,
    output t_result o_head,
    input  logic    i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           pop_fire;

    assign o_empty  = (r_count == '0);
    assign pop_fire = i_pop && !o_empty;
    assign o_space  = (r_count != CW'(DEPTH)) || pop_fire;
    assign o_head   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_res_valid) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_res_valid, pop_fire})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/word_rle_decoder_unit.sv]
// Top level of the word RLE decoder: config register, front, back and result queue.
//
// Usage:
//   Input words go in through push/full: a word (i_func, i_item_value) is taken at
//   a clock edge with push high and full low. Control bytes in place make no result;
//   every data word, and every misplaced word or control byte, makes one run descriptor.
//   Results come out through empty/pop: while empty is low the oldest descriptor
//   sits on o_run_word, o_run_count, o_image_done, o_stream_error; pop takes it.
//   A taken word passes through the front queue and the back end into the result queue.
//   Throughput: one word per cycle, set by the back-end decode state machine,
//   which retires one queued word each cycle the result queue has room.
//   A stalled receiver fills the result queue, then the front queue, then full
//   rises; nothing is dropped.
//   Configuration: total_words at APB byte address 0; the user must write it only
//   while idle, unchecked by the block; a write restarts the decoder with the new total.
//   Reset (synchronous, i_rst_n low): both queues empty, total_words = 16000,
//   decoder waits for a control byte.
module word_rle_decoder_unit
    import wrd_pkg::*;
#(
    parameter int FRONT_DEPTH = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [15:0] i_item_value,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_run_word,
    output logic [15:0] o_run_count,
    output logic        o_image_done,
    output logic        o_stream_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]  r_total_words;
    logic         cfg_we, cfg_load;
    logic         item_valid, item_pop, out_space, res_valid;
    t_item        item;
    t_result      res, head;
    t_back_status status;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign cfg_load = cfg_we && (paddr[2] == REG_TOTAL_WORDS);
    assign prdata   = (paddr[2] == REG_TOTAL_WORDS) ? {16'd0, r_total_words} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_words <= TOTAL_WORDS_RESET;
        end else if (cfg_load) begin
            r_total_words <= pwdata[15:0];
        end
    end

    wrd_front #(.DEPTH(FRONT_DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_func       (i_func),
        .i_item_value (i_item_value),
        .o_full       (full),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    wrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_load   (cfg_load),
        .i_cfg_total  (pwdata[15:0]),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_out_space  (out_space),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_status     (status)
    );

    wrd_outq #(.DEPTH(OUT_DEPTH)) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (out_space),
        .o_empty     (empty),
        .o_head      (head),
        .i_pop       (pop)
    );

    assign o_run_word     = head.run_word;
    assign o_run_count    = head.run_count;
    assign o_image_done   = head.image_done;
    assign o_stream_error = head.stream_error;

`ifndef ASSERT_OFF
    a_res_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_space)
        else $error("result produced with no room in result queue");

    a_cfg_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_load |=> (status.words_left == $past(pwdata[15:0]))
            && (status.done == ($past(pwdata[15:0]) == 16'd0)))
        else $error("total_words write did not restart the decoder");

    a_words_left_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(cfg_load)) |-> (status.words_left <= $past(status.words_left)))
        else $error("words left grew without a configuration write");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.done && !cfg_load) |=> status.done)
        else $error("decoder left the done phase without a restart");
`endif

endmodule
